// ----- design/gf2rr_pkg.sv -----
// gf2rr_pkg: shared constants and beat/command types for the GF(2) row rank block.
// No dependencies; every design file but gf2rr_ram uses it by scoped names.
package gf2rr_pkg;

	localparam int unsigned ROW_BITS  = 64;   // matrix columns, 2..64
	localparam int unsigned FIELD_W   = 64;   // width of the row field on the port
	localparam int unsigned RANK_W    = 7;
	localparam int unsigned TOP_W     = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;

	typedef struct packed {
		logic [FIELD_W-1:0] row_bits;
		logic               last_row;
	} item_t;

	typedef struct packed {
		logic              independent;
		logic [RANK_W-1:0] rank_so_far;
		logic              last_out;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture the input beat
		logic lookup;   // read the pivot at the current leading bit
		logic fold;     // xor the fetched pivot into the working row
		logic finish;   // publish the result beat
		logic insert;   // with finish: store the row as a new pivot
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic row_zero;
		logic top_valid;
	} status_t;

endpackage

// ----- design/gf2rr_ram.sv -----
// gf2rr_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module gf2rr_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/gf2rr_ctrl.sv -----
// gf2rr_ctrl: sequencer for the row reduction loop (load, lookup, fold, finish).
// Depends on gf2rr_pkg.
module gf2rr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gf2rr_pkg::status_t status,
	output gf2rr_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEAD,
		ST_FOLD
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = start && !busy_q;
		cmd.lookup = (state_q == ST_LEAD);
		case (state_q)
			ST_LEAD: begin
				if (status.row_zero) begin
					cmd.finish = 1'b1;
				end else if (!status.top_valid) begin
					cmd.finish = 1'b1;
					cmd.insert = 1'b1;
				end
			end
			ST_FOLD: cmd.fold = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_LEAD;
						busy_q  <= 1'b1;
					end
				end
				ST_LEAD: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: state_q <= ST_LEAD;
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- design/gf2rr_dp.sv -----
// gf2rr_dp: working row, leading-bit detect, pivot table with valid marks, rank counter.
// Depends on gf2rr_pkg and gf2rr_ram.
module gf2rr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  gf2rr_pkg::item_t   item,
	input  gf2rr_pkg::cmd_t    cmd,
	output gf2rr_pkg::status_t status,
	output gf2rr_pkg::result_t result
);

	localparam int unsigned RB = gf2rr_pkg::ROW_BITS;
	localparam int unsigned TW = gf2rr_pkg::TOP_W;
	localparam int unsigned RW = gf2rr_pkg::RANK_W;

	logic [RB-1:0]      row_q;
	logic               last_q;
	logic [RB-1:0]      valid_q;
	logic [RW-1:0]      rank_q;
	gf2rr_pkg::result_t result_q;

	logic [TW-1:0] top;
	logic [RB-1:0] pivot;
	logic [RW-1:0] rank_next;

	// priority encoder: highest set bit of the working row
	always_comb begin
		top = '0;
		for (int i = 0; i < RB; i++) begin
			if (row_q[i]) begin
				top = TW'(i);
			end
		end
	end

	assign status.row_zero  = (row_q == '0);
	assign status.top_valid = valid_q[top];

	gf2rr_ram #(
		.WIDTH (RB),
		.DEPTH (RB)
	) u_pivots (
		.clk   (clk),
		.we    (cmd.insert),
		.waddr (top),
		.wdata (row_q),
		.re    (cmd.lookup),
		.raddr (top),
		.rdata (pivot)
	);

	assign rank_next = rank_q + RW'(cmd.insert);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q  <= item.row_bits[RB-1:0];
			last_q <= item.last_row;
		end else if (cmd.fold) begin
			row_q <= row_q ^ pivot;
		end
		if (cmd.finish) begin
			result_q.independent <= cmd.insert;
			result_q.rank_so_far <= rank_next;
			result_q.last_out    <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
		end else if (cmd.finish) begin
			if (last_q) begin
				valid_q <= '0;
				rank_q  <= '0;
			end else begin
				if (cmd.insert) begin
					valid_q[top] <= 1'b1;
				end
				rank_q <= rank_next;
			end
		end
	end

	assign result = result_q;

endmodule

// ----- design/gf2_row_rank.sv -----
// gf2_row_rank: top level of the GF(2) matrix rank block.
// Depends on gf2rr_pkg, gf2rr_ctrl, gf2rr_dp (which holds gf2rr_ram).
//
//   channel  | handshake           | payload            | beat taken at
//   ---------+---------------------+--------------------+-------------------------
//   item     | start / busy        | item   (item_t)    | edge with start && !busy
//   result   | done (1-cycle pulse)| result (result_t)  | edge closing the done cycle
//
// Each pivot folded into a row (0..ROW_BITS of them) costs a lookup step in
// ST_LEAD plus a fold step in ST_FOLD that takes the registered pivot read;
// a row that needs no fold finishes from its first ST_LEAD step.
// busy drops in the cycle done is high; a new row may start in that cycle.
// Reset (arst_n low) empties the pivot valid marks and zeroes the rank; the
// pivot RAM itself is not cleared. The receiver cannot stall result beats.
// After a beat with last_row set, valid marks and rank clear for the next matrix.
module gf2_row_rank (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gf2rr_pkg::item_t   item,
	output logic               busy,
	output logic               done,
	output gf2rr_pkg::result_t result
);

	gf2rr_pkg::cmd_t    cmd;
	gf2rr_pkg::status_t status;

	gf2rr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gf2rr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule
